// File: rtl/sfl_pkg.sv
// sfl_pkg: shared constants for the byte shuffle block
// holds the weyl step, the two mixing multipliers and their shift amounts
// no dependencies
package sfl_pkg;

   localparam int unsigned WORD_W  = 64;
   localparam int unsigned HALF_W  = 32;
   localparam int unsigned NBITS_W = 7;

   localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;

   localparam int unsigned SHIFT_A = 30;
   localparam int unsigned SHIFT_B = 27;

   // operand selection of the shared multiplier within one 64-bit product
   localparam logic [1:0] MUL_LL   = 2'd0;
   localparam logic [1:0] MUL_LH   = 2'd1;
   localparam logic [1:0] MUL_HL   = 2'd2;
   localparam logic [1:0] MUL_LAST = 2'd3;

endpackage

// File: rtl/sfl_mix_unit.sv
// sfl_mix_unit: the two xor-shift-multiply rounds of the mixer
// one shared 32x32 multiplier builds each 64-bit product from three partials
// depends on sfl_pkg
module sfl_mix_unit
   import sfl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] seed,
   output logic              done,
   output logic [WORD_W-1:0] result
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              round_ff, round_in;
   logic [1:0]        step_ff, step_in;
   logic [WORD_W-1:0] x_ff, x_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] prod_ff;
   logic [WORD_W-1:0] mul_k;
   logic [HALF_W-1:0] mul_a, mul_b;

   assign mul_k = round_ff ? MIX_MUL_B : MIX_MUL_A;

   always_comb begin
      unique case (step_ff)
         MUL_LL: begin
            mul_a = x_ff[HALF_W-1:0];
            mul_b = mul_k[HALF_W-1:0];
         end
         MUL_LH: begin
            mul_a = x_ff[HALF_W-1:0];
            mul_b = mul_k[WORD_W-1:HALF_W];
         end
         MUL_HL: begin
            mul_a = x_ff[WORD_W-1:HALF_W];
            mul_b = mul_k[HALF_W-1:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      round_in = round_ff;
      step_in  = step_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         round_in = 1'b0;
         step_in  = MUL_LL;
         x_in     = seed ^ (seed >> SHIFT_A);
      end else if (busy_ff) begin
         step_in = step_ff + 2'd1;
         unique case (step_ff)
            MUL_LL:  acc_in = acc_ff;
            MUL_LH:  acc_in = prod_ff;
            default: acc_in = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
         endcase
         if (step_ff == MUL_LAST) begin
            if (!round_ff) begin
               round_in = 1'b1;
               x_in     = acc_in ^ (acc_in >> SHIFT_B);
            end else begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= 1'b0;
         step_ff  <= MUL_LL;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         round_ff <= round_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      prod_ff <= mul_a * mul_b;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

// File: rtl/sfl_mod_unit.sv
// sfl_mod_unit: bit-serial restoring remainder, one dividend bit a cycle
// dividend bits are taken from the top, nbits of them
// depends on sfl_pkg
module sfl_mod_unit
   import sfl_pkg::*;
#(
   parameter int unsigned DIV_W = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WORD_W-1:0]  dividend,
   input  logic [DIV_W-1:0]   divisor,
   input  logic [NBITS_W-1:0] nbits,
   output logic               done,
   output logic [DIV_W-1:0]   remainder
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [NBITS_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]   div_ff, div_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W:0]     trial;
   logic [DIV_W:0]     diff;

   assign trial = {rem_ff, dvd_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = nbits;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, div_ff}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff - NBITS_W'(1);
         if (cnt_ff == NBITS_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: rtl/sfl_store.sv
// sfl_store: byte buffer, one write port and one registered read port
// depends on sfl_pkg for nothing but the house layout
module sfl_store
   import sfl_pkg::*;
#(
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/byte_shuffle_splitmix_unit.sv
// byte_shuffle_splitmix_unit: top level of the byte shuffler
// uses sfl_pkg, sfl_store, sfl_mix_unit and sfl_mod_unit
//
// usage
//   req_ channel: one byte a word; req_last_in closes a batch. bytes past
//   MAX_ITEMS are dropped, but a dropped word with last still closes the batch
//   rsp_ channel: the shuffled batch, one byte a word, position counting up
//   from 0, rsp_out_last on the final byte
//   csr_ channel: writing csr_seed_value reloads the weyl counter; take it only
//   while the block is loading
// timing
//   loading takes one byte a cycle; req_stall is low only while loading
//   a batch of n bytes then runs n-1 swap steps, each of them a weyl advance,
//   the mixer (the shared 32x32 multiplier, three partials per 64-bit product
//   over two rounds, then done seen), the bit-serial remainder by n, the
//   remainder by i+1, and four store accesses
//   output then reads and puts each byte in turn through the single read port
// reset and stall
//   reset empties the buffer and sets the weyl counter to the golden step
//   a stalled rsp_ word holds in its output register; the sequencer waits
module byte_shuffle_splitmix_unit
   import sfl_pkg::*;
#(
   parameter int unsigned MAX_ITEMS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_element_byte,
   input  logic              req_last_in,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic [5:0]        rsp_out_position,
   output logic              rsp_out_last,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [WORD_W-1:0] csr_seed_value
);

   localparam int unsigned ADDR_W = $clog2(MAX_ITEMS);
   localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);

   // sequencer codes
   localparam logic [3:0] ST_LOAD    = 4'd0;
   localparam logic [3:0] ST_STEP    = 4'd1;
   localparam logic [3:0] ST_MIX     = 4'd2;
   localparam logic [3:0] ST_MOD_N   = 4'd3;
   localparam logic [3:0] ST_MOD_I   = 4'd4;
   localparam logic [3:0] ST_RD_I    = 4'd5;
   localparam logic [3:0] ST_RD_J    = 4'd6;
   localparam logic [3:0] ST_WR_I    = 4'd7;
   localparam logic [3:0] ST_WR_J    = 4'd8;
   localparam logic [3:0] ST_OUT_RD  = 4'd9;
   localparam logic [3:0] ST_OUT_PUT = 4'd10;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic [7:0]        tmp_ff, tmp_in;
   logic [WORD_W-1:0] weyl_ff, weyl_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic [5:0]        rsp_pos_ff, rsp_pos_in;
   logic              rsp_last_ff, rsp_last_in;

   // store ports
   logic              st_wr_en;
   logic [ADDR_W-1:0] st_wr_addr;
   logic [7:0]        st_wr_data;
   logic [ADDR_W-1:0] st_rd_addr;
   logic [7:0]        st_rd_data;

   // shared units
   logic              mix_start, mix_done;
   logic [WORD_W-1:0] mix_seed, mix_result;
   logic              mod_start, mod_done;
   logic [WORD_W-1:0] mod_dividend;
   logic [CNT_W-1:0]  mod_divisor, mod_rem;
   logic [NBITS_W-1:0] mod_nbits;

   logic              req_take;
   logic              out_free;
   logic [CNT_W-1:0]  fill_next;
   logic [WORD_W-1:0] weyl_step;

   assign req_take  = req_valid && (state_ff == ST_LOAD);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fill_next = (fill_ff < CNT_W'(MAX_ITEMS)) ? fill_ff + CNT_W'(1) : fill_ff;
   assign weyl_step = weyl_ff + GOLDEN_STEP;
   assign mix_seed  = weyl_step;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      tmp_in       = tmp_ff;
      weyl_in      = weyl_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      st_wr_en     = 1'b0;
      st_wr_addr   = i_ff;
      st_wr_data   = st_rd_data;
      st_rd_addr   = i_ff;
      mix_start    = 1'b0;
      mod_start    = 1'b0;
      mod_dividend = mix_result;
      mod_divisor  = n_ff;
      mod_nbits    = NBITS_W'(WORD_W);

      unique case (state_ff)
         ST_LOAD: begin
            if (csr_valid) begin
               weyl_in = csr_seed_value;
            end
            if (req_take) begin
               // a byte past capacity is dropped
               if (fill_ff < CNT_W'(MAX_ITEMS)) begin
                  st_wr_en   = 1'b1;
                  st_wr_addr = fill_ff[ADDR_W-1:0];
                  st_wr_data = req_element_byte;
               end
               fill_in = fill_next;
               if (req_last_in) begin
                  n_in = fill_next;
                  i_in = ADDR_W'(fill_next - CNT_W'(1));
                  k_in = '0;
                  // a single byte needs no swap
                  state_in = (fill_next == CNT_W'(1)) ? ST_OUT_RD : ST_STEP;
               end
            end
         end
         ST_STEP: begin
            weyl_in   = weyl_step;
            mix_start = 1'b1;
            state_in  = ST_MIX;
         end
         ST_MIX: begin
            if (mix_done) begin
               mod_start = 1'b1;
               state_in  = ST_MOD_N;
            end
         end
         ST_MOD_N: begin
            // second reduction: the remainder by n, now by i+1
            mod_dividend = {mod_rem, {(WORD_W - CNT_W){1'b0}}};
            mod_divisor  = CNT_W'(i_ff) + CNT_W'(1);
            mod_nbits    = NBITS_W'(CNT_W);
            if (mod_done) begin
               mod_start = 1'b1;
               state_in  = ST_MOD_I;
            end
         end
         ST_MOD_I: begin
            if (mod_done) begin
               j_in     = mod_rem[ADDR_W-1:0];
               state_in = ST_RD_I;
            end
         end
         ST_RD_I: begin
            st_rd_addr = i_ff;
            state_in   = ST_RD_J;
         end
         ST_RD_J: begin
            st_rd_addr = j_ff;
            tmp_in     = st_rd_data;
            state_in   = ST_WR_I;
         end
         ST_WR_I: begin
            st_wr_en   = 1'b1;
            st_wr_addr = i_ff;
            st_wr_data = st_rd_data;
            state_in   = ST_WR_J;
         end
         ST_WR_J: begin
            st_wr_en   = 1'b1;
            st_wr_addr = j_ff;
            st_wr_data = tmp_ff;
            if (i_ff == ADDR_W'(1)) begin
               state_in = ST_OUT_RD;
            end else begin
               i_in     = i_ff - ADDR_W'(1);
               state_in = ST_STEP;
            end
         end
         ST_OUT_RD: begin
            st_rd_addr = k_ff;
            state_in   = ST_OUT_PUT;
         end
         ST_OUT_PUT: begin
            st_rd_addr = k_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = st_rd_data;
               rsp_pos_in   = 6'(k_ff);
               rsp_last_in  = (CNT_W'(k_ff) + CNT_W'(1)) == n_ff;
               if (rsp_last_in) begin
                  fill_in  = '0;
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_ff + ADDR_W'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         fill_ff      <= '0;
         weyl_ff      <= GOLDEN_STEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         weyl_ff      <= weyl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      tmp_ff      <= tmp_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   sfl_store #(
      .DEPTH  (MAX_ITEMS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   sfl_mix_unit u_mix (
      .clock  (clock),
      .reset  (reset),
      .start  (mix_start),
      .seed   (mix_seed),
      .done   (mix_done),
      .result (mix_result)
   );

   sfl_mod_unit #(
      .DIV_W (CNT_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .nbits     (mod_nbits),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign req_stall        = (state_ff != ST_LOAD);
   assign csr_ready        = (state_ff == ST_LOAD);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_out_position = rsp_pos_ff;
   assign rsp_out_last     = rsp_last_ff;

endmodule

// File: tb/sv/shuffle_order_check.sv
// shuffle_order_check: watches the req_, rsp_ and csr_ channels of the byte shuffler
// keeps its own byte store and weyl counter, and checks every rsp_ word in order
// depends on sfl_pkg for the seed width only
module shuffle_order_check
   import sfl_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [7:0]        req_element_byte,
   input  logic              req_last_in,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [7:0]        rsp_out_byte,
   input  logic [5:0]        rsp_out_position,
   input  logic              rsp_out_last,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [WORD_W-1:0] csr_seed_value,
   output int                fail_count,
   output int                pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] WEYL_STEP = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [63:0] MULT_ONE  = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [63:0] MULT_TWO  = 64'h94d0_49bb_1331_11eb;

   typedef struct packed {
      logic [7:0] value;
      logic [5:0] position;
      logic       last;
   } shuffled_word_type;

   logic [7:0]        held_bytes [CAPACITY];
   int unsigned       fill_level;
   logic [63:0]       weyl;
   shuffled_word_type shuffled_q [$];
   shuffled_word_type got;
   shuffled_word_type want;
   int                errors;

   // advance the weyl counter and mix it, without the closing xor-shift
   function automatic logic [63:0] mix_next();
      logic [63:0] z;
      weyl = weyl + WEYL_STEP;
      z = weyl;
      z = (z ^ (z >> 30)) * MULT_ONE;
      z = (z ^ (z >> 27)) * MULT_TWO;
      return z;
   endfunction

   // store one byte and, on a closing word, shuffle the batch and queue its words
   task automatic take_word(input logic [7:0] value, input logic closes);
      int unsigned n;
      int unsigned i;
      int unsigned k;
      logic [63:0] r;
      int unsigned j;
      logic [7:0]  t;
      shuffled_word_type w;
      if (fill_level < CAPACITY) begin
         held_bytes[fill_level] = value;
         fill_level++;
      end
      if (closes) begin
         n = fill_level;
         for (i = n - 1; i > 0; i--) begin
            r = mix_next() % 64'(n);
            j = int'(r % 64'(i + 1));
            t = held_bytes[i];
            held_bytes[i] = held_bytes[j];
            held_bytes[j] = t;
         end
         for (k = 0; k < n; k++) begin
            w.value = held_bytes[k];
            w.position = 6'(k);
            w.last = (k == n - 1);
            shuffled_q.push_back(w);
         end
         fill_level = 0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill_level = 0;
         weyl = WEYL_STEP;
         shuffled_q.delete();
         errors = 0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got = '{rsp_out_byte, rsp_out_position, rsp_out_last};
            if (shuffled_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected rsp word byte %02h pos %0d last %0b",
                        $time, got.value, got.position, got.last);
            end else begin
               want = shuffled_q.pop_front();
               if (got.value !== want.value || got.position !== want.position ||
                   got.last !== want.last) begin
                  errors++;
                  $display({"%0t: rsp mismatch, expected byte %02h pos %0d last %0b, ",
                            "got byte %02h pos %0d last %0b"},
                           $time, want.value, want.position, want.last,
                           got.value, got.position, got.last);
               end
            end
         end
         // seed write reloads the counter
         if (csr_valid === 1'b1 && csr_ready === 1'b1)
            weyl = csr_seed_value;
         if (req_valid === 1'b1 && req_stall === 1'b0)
            take_word(req_element_byte, req_last_in);
      end
      fail_count <= errors;
      pending_words <= shuffled_q.size();
   end

endmodule

// File: tb/sv/byte_shuffle_splitmix_unit_test.sv
// byte_shuffle_splitmix_unit_test: stimulus and verdict for the byte shuffler
// sends batches of bytes, writes the seed between phases and applies back-pressure
// depends on sfl_pkg, byte_shuffle_splitmix_unit and shuffle_order_check
module byte_shuffle_splitmix_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sfl_pkg::*;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [7:0]        req_element_byte;
   logic              req_last_in;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [7:0]        rsp_out_byte;
   logic [5:0]        rsp_out_position;
   logic              rsp_out_last;
   logic              csr_valid;
   logic              csr_ready;
   logic [WORD_W-1:0] csr_seed_value;

   int          mismatches;
   int          pending_words;
   // chance in a hundred that the sender idles or the receiver stalls on a cycle
   int unsigned idle_pct;
   int unsigned stall_pct;

   byte_shuffle_splitmix_unit #(
      .MAX_ITEMS(64)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_element_byte(req_element_byte),
      .req_last_in(req_last_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_out_position(rsp_out_position),
      .rsp_out_last(rsp_out_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_seed_value(csr_seed_value)
   );

   shuffle_order_check #(
      .CAPACITY(64)
   ) order_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_element_byte(req_element_byte),
      .req_last_in(req_last_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_out_position(rsp_out_position),
      .rsp_out_last(rsp_out_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_seed_value(csr_seed_value),
      .fail_count(mismatches),
      .pending_words(pending_words)
   );

   always #5 clock = ~clock;

   // receiver back-pressure, redrawn every falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // one req word: random idle gap first, then hold it until the block takes it
   task automatic send_word(input logic [7:0] value, input logic closes);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_element_byte <= value;
      req_last_in <= closes;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // a batch of random bytes, the final one closing it
   task automatic send_random_batch(input int unsigned count);
      int unsigned k;
      for (k = 0; k < count; k++)
         send_word(8'($urandom_range(255)), k == count - 1);
   endtask

   // drop valid, let every shuffled word come back, then let the block settle
   // into loading before anything else happens
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // seed writes happen only while the block is idle and loading
   task automatic write_seed(input logic [WORD_W-1:0] seed);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_seed_value <= seed;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one random phase: mostly short batches, now and then a medium one; an
   // overflow phase opens with a batch past capacity whose closing byte is dropped
   task automatic run_phase(input int unsigned idle, input int unsigned stall,
                            input int unsigned budget, input bit overflow);
      int unsigned sent;
      int unsigned count;
      idle_pct = idle;
      stall_pct = stall;
      sent = 0;
      if (overflow) begin
         count = $urandom_range(65, 67);
         send_random_batch(count);
         sent += count;
      end
      while (sent < budget) begin
         if ($urandom_range(9) == 0)
            count = $urandom_range(9, 24);
         else
            count = $urandom_range(1, 8);
         send_random_batch(count);
         sent += count;
      end
      settle();
   endtask

   // directed batches: single bytes, a pair, byte extremes, alternating bits and a stepped run
   logic [7:0] directed_bytes [21] = '{
      8'h00,
      8'hff,
      8'h00, 8'hff,
      8'h80, 8'h01, 8'h7f,
      8'ha5, 8'h5a, 8'hc3, 8'h3c, 8'hff, 8'h00,
      8'h10, 8'h21, 8'h32, 8'h43, 8'h54, 8'h65, 8'h76, 8'h87
   };
   logic directed_close [21] = '{
      1'b1,
      1'b1,
      1'b0, 1'b1,
      1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
   };

   initial begin
      int unsigned k;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_element_byte = '0;
      req_last_in = 1'b0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_seed_value = '0;
      idle_pct = 0;
      stall_pct = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part runs on the counter value left by reset
      for (k = 0; k < 21; k++)
         send_word(directed_bytes[k], directed_close[k]);
      settle();

      // random phases, each on a fresh seed: zero, all ones, then random
      write_seed('0);
      run_phase(0, 0, 52, 1'b0);
      write_seed('1);
      run_phase(83, 0, 52, 1'b0);
      write_seed({$urandom, $urandom});
      run_phase(0, 83, 52, 1'b1);
      write_seed({$urandom, $urandom});
      run_phase(6, 6, 52, 1'b0);

      // quiet tail to catch any stray rsp word
      stall_pct = 0;
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
